/* src/adaptive_playout_delay_controller_macros.svh */
// Assertion macros shared by the playout delay controller checker.
// Each macro needs clk in scope; all but APDC_ASSERT_RST also need rst_n.
`ifndef ADAPTIVE_PLAYOUT_DELAY_CONTROLLER_MACROS_SVH
`define ADAPTIVE_PLAYOUT_DELAY_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define APDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define APDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that stays live through reset.
`define APDC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* src/apdc_pkg.sv */
// Package for the adaptive playout delay controller: field widths, operation
// codes, register indexes, register reset values and the divide-by-1000 constants.
// No dependencies.
`timescale 1ns / 1ps

package apdc_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0]    time_us_t;
  typedef logic [MS_W-1:0]      ms_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Operation codes carried on in_tuser.
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Register indexes on the configuration port.
  localparam cfg_idx_t REG_DEFAULT_DELAY  = 3'd0;
  localparam cfg_idx_t REG_MIN_DELAY      = 3'd1;
  localparam cfg_idx_t REG_MAX_DELAY      = 3'd2;
  localparam cfg_idx_t REG_REQUESTED      = 3'd3;
  localparam cfg_idx_t REG_HOLD           = 3'd4;
  localparam cfg_idx_t REG_STEP           = 3'd5;
  localparam cfg_idx_t REG_STEP_INTERVAL  = 3'd6;
  localparam cfg_idx_t REG_DEFAULT_TICK   = 3'd7;

  // Register values after reset.
  localparam ms_t RST_DEFAULT_DELAY = 16'd100;
  localparam ms_t RST_MIN_DELAY     = 16'd50;
  localparam ms_t RST_MAX_DELAY     = 16'd500;
  localparam ms_t RST_REQUESTED     = 16'd100;
  localparam ms_t RST_HOLD          = 16'd1000;
  localparam ms_t RST_STEP          = 16'd5;
  localparam ms_t RST_STEP_INTERVAL = 16'd100;
  localparam ms_t RST_DEFAULT_TICK  = 16'd33;
  // Effective default of the reset register values.
  localparam ms_t RST_CUR_DELAY     = 16'd100;

  // Lag values at or above 2^LAG_W us always saturate the needed delay.
  localparam int unsigned LAG_W      = 26;
  localparam int unsigned LAG_X_W    = LAG_W + 1;
  localparam int unsigned US_PER_MS  = 1000;
  localparam int unsigned CEIL_ADD   = US_PER_MS - 1;
  // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT for x < 2^27.
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
  localparam int unsigned LAG_MS_W   = 17;
  localparam int unsigned HOLD_US_W  = 26;

endpackage

/* src/adaptive_playout_delay_controller.sv */
// Adaptive playout delay controller: one result beat per input beat.
// An accepted input beat passes the input register and then the result register.
// Throughput: one beat per cycle; an input register, loaded on in_tready, and a
// result register, loaded on advance, keep the pipe moving while out_tready is high.
// Reset (rst_n low, synchronous) restores register defaults, sets the delay
// to 100 ms, clears the pending decrease and the timer, and empties the pipe.
// Depends on apdc_pkg.
`timescale 1ns / 1ps

module adaptive_playout_delay_controller (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // [47:0] arrival_us, [95:48] sample_us, [111:96] tick_ms
  input  logic         in_tuser,  // [0] op: 0 observe, 1 restart
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata, // [15:0] delay_ms
  output logic         out_tuser, // [0] decrease_pending
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // Configuration registers.
  apdc_pkg::ms_t default_delay_r, min_delay_r, max_delay_r, requested_r;
  apdc_pkg::ms_t hold_r, step_r, step_interval_r, default_tick_r;

  // Input register stage.
  logic               s1_valid_r;
  logic               s1_op_r;
  apdc_pkg::time_us_t s1_arrival_r, s1_sample_r;
  apdc_pkg::ms_t      s1_tick_r;

  // Controller state.
  apdc_pkg::ms_t      cur_delay_r, cur_delay_nxt;
  logic               dec_sched_r, dec_sched_nxt;
  apdc_pkg::time_us_t next_dec_r, next_dec_nxt;

  // Result register.
  logic               out_valid_r;
  apdc_pkg::ms_t      out_delay_r;
  logic               out_pend_r;

  // The pipe advances when the result register is empty or being drained.
  logic advance;
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = advance || !s1_valid_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_delay_r;
  assign out_tuser  = out_pend_r;

  // Effective limits: the maximum is at least the minimum and the default
  // is clamped into [minimum, effective maximum].
  apdc_pkg::ms_t eff_max, eff_default, def_lo;
  assign eff_max     = (max_delay_r > min_delay_r) ? max_delay_r : min_delay_r;
  assign def_lo      = (default_delay_r < min_delay_r) ? min_delay_r : default_delay_r;
  assign eff_default = (def_lo > eff_max) ? eff_max : def_lo;

  // Needed delay. The lag is rounded up to whole milliseconds with a
  // reciprocal multiply; any lag of 2^26 us or more saturates anyway, so only
  // the low 26 bits ever go through the multiplier.
  apdc_pkg::ms_t                       tick_eff, need, target;
  logic                                arr_after;
  apdc_pkg::time_us_t                  diff;
  logic                                lag_big;
  logic [apdc_pkg::LAG_X_W-1:0]        lag_x;
  logic [apdc_pkg::LAG_X_W+apdc_pkg::RECIP_W-1:0] lag_prod;
  logic [apdc_pkg::LAG_MS_W-1:0]       lag_ms;
  logic [apdc_pkg::LAG_MS_W:0]         lag_sum;

  assign tick_eff  = (s1_tick_r == '0) ? default_tick_r : s1_tick_r;
  assign arr_after = s1_arrival_r > s1_sample_r;
  assign diff      = s1_arrival_r - s1_sample_r;
  assign lag_big   = |diff[apdc_pkg::TIME_W-1:apdc_pkg::LAG_W];
  assign lag_x     = {1'b0, diff[apdc_pkg::LAG_W-1:0]}
                     + apdc_pkg::LAG_X_W'(apdc_pkg::CEIL_ADD);
  assign lag_prod  = (apdc_pkg::LAG_X_W+apdc_pkg::RECIP_W)'(lag_x)
                     * (apdc_pkg::LAG_X_W+apdc_pkg::RECIP_W)'(apdc_pkg::RECIP);
  assign lag_ms    = lag_prod[apdc_pkg::RECIP_SHIFT +: apdc_pkg::LAG_MS_W];
  assign lag_sum   = {1'b0, lag_ms} + (apdc_pkg::LAG_MS_W+1)'(tick_eff);

  always_comb begin
    if (!arr_after) begin
      need = tick_eff;
    end else if (lag_big || (|lag_sum[apdc_pkg::LAG_MS_W:apdc_pkg::MS_W])) begin
      need = '1;
    end else begin
      need = lag_sum[apdc_pkg::MS_W-1:0];
    end
  end

  assign target = (requested_r > need) ? requested_r : need;

  // Timer deadlines; both wrap modulo 2^48.
  logic [apdc_pkg::HOLD_US_W-1:0] hold_us, interval_us;
  apdc_pkg::time_us_t             hold_deadline, step_deadline;
  assign hold_us       = apdc_pkg::HOLD_US_W'(hold_r)
                         * apdc_pkg::HOLD_US_W'(apdc_pkg::US_PER_MS);
  assign interval_us   = apdc_pkg::HOLD_US_W'(step_interval_r)
                         * apdc_pkg::HOLD_US_W'(apdc_pkg::US_PER_MS);
  assign hold_deadline = s1_arrival_r + apdc_pkg::TIME_W'(hold_us);
  assign step_deadline = s1_arrival_r + apdc_pkg::TIME_W'(interval_us);

  // Delay update. Restart loads the effective default; a higher or equal target is taken
  // at once, capped at the effective maximum; a lower one first arms the hold timer, then
  // steps down once per interval and lands on the target when a step would reach it.
  apdc_pkg::ms_t gap;
  assign gap = cur_delay_r - target;

  always_comb begin
    cur_delay_nxt = cur_delay_r;
    dec_sched_nxt = dec_sched_r;
    next_dec_nxt  = next_dec_r;
    if (s1_op_r == apdc_pkg::OP_RESTART) begin
      cur_delay_nxt = eff_default;
      dec_sched_nxt = 1'b0;
    end else if (target >= cur_delay_r) begin
      cur_delay_nxt = (target < eff_max) ? target : eff_max;
      dec_sched_nxt = 1'b0;
    end else if (!dec_sched_r) begin
      next_dec_nxt  = hold_deadline;
      dec_sched_nxt = 1'b1;
    end else if (s1_arrival_r >= next_dec_r) begin
      if (step_r >= gap) begin
        cur_delay_nxt = target;
        dec_sched_nxt = 1'b0;
      end else begin
        cur_delay_nxt = cur_delay_r - step_r;
        next_dec_nxt  = step_deadline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_delay_r <= apdc_pkg::RST_DEFAULT_DELAY;
      min_delay_r     <= apdc_pkg::RST_MIN_DELAY;
      max_delay_r     <= apdc_pkg::RST_MAX_DELAY;
      requested_r     <= apdc_pkg::RST_REQUESTED;
      hold_r          <= apdc_pkg::RST_HOLD;
      step_r          <= apdc_pkg::RST_STEP;
      step_interval_r <= apdc_pkg::RST_STEP_INTERVAL;
      default_tick_r  <= apdc_pkg::RST_DEFAULT_TICK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apdc_pkg::REG_DEFAULT_DELAY: default_delay_r <= cfg_data;
        apdc_pkg::REG_MIN_DELAY:     min_delay_r     <= cfg_data;
        apdc_pkg::REG_MAX_DELAY:     max_delay_r     <= cfg_data;
        apdc_pkg::REG_REQUESTED:     requested_r     <= cfg_data;
        apdc_pkg::REG_HOLD:          hold_r          <= cfg_data;
        apdc_pkg::REG_STEP:          step_r          <= cfg_data;
        apdc_pkg::REG_STEP_INTERVAL: step_interval_r <= cfg_data;
        apdc_pkg::REG_DEFAULT_TICK:  default_tick_r  <= cfg_data;
      endcase
    end
  end

  // Input register: loads whenever a beat is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r      <= in_tuser;
      s1_arrival_r <= in_tdata[47:0];
      s1_sample_r  <= in_tdata[95:48];
      s1_tick_r    <= in_tdata[111:96];
    end
  end

  // State and result register: updated when the staged beat moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_delay_r <= apdc_pkg::RST_CUR_DELAY;
      dec_sched_r <= 1'b0;
      next_dec_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        cur_delay_r <= cur_delay_nxt;
        dec_sched_r <= dec_sched_nxt;
        next_dec_r  <= next_dec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_delay_r <= cur_delay_nxt;
      out_pend_r  <= dec_sched_nxt;
    end
  end

endmodule

/* src/apdc_checker.sv */
// Port-level checker for the adaptive playout delay controller, and its bind.
// Depends on adaptive_playout_delay_controller_macros.svh.
`timescale 1ns / 1ps
`include "adaptive_playout_delay_controller_macros.svh"

module apdc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [15:0]  out_tdata,
  input logic         out_tuser
);

  // A stalled result beat holds its value.
  `APDC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Every accepted beat is checked to show a valid result after the input and result registers.
  `APDC_ASSERT_NXT(a_latency, in_tvalid && in_tready, ##1 out_tvalid)

  // With the result register empty the block takes input.
  `APDC_ASSERT_IMP(a_ready_empty, !out_tvalid, in_tready)

  // Reset empties the result register.
  `APDC_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind adaptive_playout_delay_controller apdc_checker u_apdc_checker (.*);
